@@ rtl/sca_pkg.sv @@
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants, types and helpers of the size-class block allocator.
// ----------------------------------------------------------------------------
package sca_pkg;

	localparam int NUM_CLASSES = 26;
	localparam int STACK_DEPTH = 64;
	localparam int MIN_BLOCK   = 64;

	localparam int ADDR_W    = 32;
	localparam int CLASS_W   = 5;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W     = $clog2(STACK_DEPTH);
	localparam int MEM_DEPTH = NUM_CLASSES * STACK_DEPTH;
	localparam int MEM_AW    = $clog2(MEM_DEPTH);
	localparam int BYTES_W   = ADDR_W + 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK_STACK   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OK_BUMP    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_HEAP    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'd1;

	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic               too_large;
	} class_sel_t;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] waddr;
		logic [ADDR_W-1:0] wdata;
		logic              re;
		logic [MEM_AW-1:0] raddr;
	} mem_req_t;

	function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] cls);
		return BYTES_W'(MIN_BLOCK) << cls;
	endfunction

	function automatic logic [MEM_AW-1:0] stack_addr(input logic [CLASS_W-1:0] cls,
		input logic [IDX_W-1:0] idx);
		return MEM_AW'(cls) * MEM_AW'(STACK_DEPTH) + MEM_AW'(idx);
	endfunction

endpackage

@@ rtl/sca_if.sv @@
// ----------------------------------------------------------------------------
// sca_if
// Request and response channels of the size-class block allocator.
// ----------------------------------------------------------------------------
interface sca_req_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [sca_pkg::ADDR_W-1:0]   alloc_size;
	logic [sca_pkg::ADDR_W-1:0]   free_address;
	logic [sca_pkg::CLASS_W-1:0]  free_class;

	modport source (output valid, cmd, alloc_size, free_address, free_class, input ready);
	modport sink   (input valid, cmd, alloc_size, free_address, free_class, output ready);
endinterface

interface sca_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [sca_pkg::ADDR_W-1:0]   block_address;
	logic [sca_pkg::CLASS_W-1:0]  size_class;
	logic [sca_pkg::STATUS_W-1:0] status;

	modport source (output valid, block_address, size_class, status, input ready);
	modport sink   (input valid, block_address, size_class, status, output ready);
endinterface

@@ rtl/sca_class_sel.sv @@
// ----------------------------------------------------------------------------
// sca_class_sel
// Picks the smallest power-of-two size class that holds a byte count.
// ----------------------------------------------------------------------------
module sca_class_sel (
	input  logic [sca_pkg::ADDR_W-1:0] size,
	output sca_pkg::class_sel_t        sel
);
	import sca_pkg::*;

	logic [NUM_CLASSES-1:0] hit;

	always_comb begin
		for (int k = 0; k < NUM_CLASSES; k++) begin
			hit[k] = {1'b0, size} <= class_bytes(CLASS_W'(k));
		end
	end

	always_comb begin
		sel.cls = '0;
		for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
			if (hit[k]) begin
				sel.cls = CLASS_W'(k);
			end
		end
		sel.too_large = ~|hit;
	end

endmodule

@@ rtl/sca_stack_mem.sv @@
// ----------------------------------------------------------------------------
// sca_stack_mem
// Free-stack entry memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sca_stack_mem (
	input  logic                       clk,
	input  sca_pkg::mem_req_t          req,
	output logic [sca_pkg::ADDR_W-1:0] rdata
);
	import sca_pkg::*;

	logic [ADDR_W-1:0] mem [MEM_DEPTH];
	logic [ADDR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/size_class_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// size_class_block_allocator_core
// Power-of-two size-class allocator with per-class free stacks and a bump
// pointer behind them.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | cmd, alloc_size, free_address, free_class
//  rsp     | out       | block_address, size_class, status
//  cfg     | in        | cfg_we, cfg_index, cfg_wdata (heap_start, heap_limit)
//
// A transaction passes through an execute state that updates the class
// count, the bump pointer and the stack memory port, then a response state
// that captures the memory read data into the output register.
// The next request is taken in the response state, so a new transaction
// starts as the last response is registered while the response side keeps up.
// A stalled response holds the block in the response state.
// Reset clears the counts at once; the stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	sca_req_if.sink                       req,
	sca_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [sca_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sca_pkg::ADDR_W-1:0]    cfg_wdata
);
	import sca_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0]          state_q;
	logic [ADDR_W-1:0]   heap_limit_q;
	logic [ADDR_W-1:0]   bump_top_q;
	logic [CNT_W-1:0]    cnt_q [NUM_CLASSES];

	logic                cmd_s1;
	logic [CLASS_W-1:0]  cls_s1;
	logic                too_large_s1;
	logic [ADDR_W-1:0]   addr_s1;

	logic [ADDR_W-1:0]   res_addr_s2;
	logic [CLASS_W-1:0]  res_cls_s2;
	logic [STATUS_W-1:0] res_status_s2;
	logic                from_mem_s2;

	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	logic [CLASS_W-1:0]  out_cls_q;
	logic [STATUS_W-1:0] out_status_q;

	class_sel_t          sel;
	mem_req_t            mem_req;
	logic [ADDR_W-1:0]   mem_rdata;

	logic                out_free;
	logic                req_acc;
	logic                cls_ok;
	logic [CNT_W-1:0]    cnt_cur;
	logic [BYTES_W-1:0]  new_top;

	logic [ADDR_W-1:0]   ex_addr;
	logic [CLASS_W-1:0]  ex_cls;
	logic [STATUS_W-1:0] ex_status;
	logic                ex_from_mem;
	logic                ex_pop;
	logic                ex_push;
	logic                ex_bump;

	sca_class_sel u_class_sel (
		.size (req.alloc_size),
		.sel  (sel)
	);

	sca_stack_mem u_stack_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) || (state_q == S_RESP && out_free);
	assign req_acc   = req.valid && req.ready;

	assign cls_ok  = cls_s1 < CLASS_W'(NUM_CLASSES);
	assign cnt_cur = cls_ok ? cnt_q[cls_s1] : '0;
	assign new_top = {1'b0, bump_top_q} + class_bytes(cls_s1);

	always_comb begin
		ex_addr     = '0;
		ex_cls      = cls_s1;
		ex_status   = ST_OK_STACK;
		ex_from_mem = 1'b0;
		ex_pop      = 1'b0;
		ex_push     = 1'b0;
		ex_bump     = 1'b0;
		if (cmd_s1 == CMD_ALLOC) begin
			if (too_large_s1) begin
				ex_cls    = '0;
				ex_status = ST_TOO_LARGE;
			end else if (cnt_cur != '0) begin
				ex_pop      = 1'b1;
				ex_from_mem = 1'b1;
			end else if ({1'b0, heap_limit_q} <= new_top) begin
				ex_status = ST_NO_HEAP;
			end else begin
				ex_bump   = 1'b1;
				ex_addr   = bump_top_q;
				ex_status = ST_OK_BUMP;
			end
		end else begin
			if (!cls_ok || cnt_cur >= CNT_W'(STACK_DEPTH)) begin
				ex_status = ST_STACK_FULL;
			end else begin
				ex_push = 1'b1;
			end
		end
	end

	always_comb begin
		mem_req.we    = (state_q == S_EXEC) && ex_push;
		mem_req.waddr = stack_addr(cls_s1, IDX_W'(cnt_cur));
		mem_req.wdata = addr_s1;
		mem_req.re    = (state_q == S_EXEC) && ex_pop;
		mem_req.raddr = stack_addr(cls_s1, IDX_W'(cnt_cur - CNT_W'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			heap_limit_q <= '0;
			bump_top_q   <= '0;
			out_valid_q  <= 1'b0;
			for (int k = 0; k < NUM_CLASSES; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					if (ex_pop) begin
						cnt_q[cls_s1] <= cnt_cur - CNT_W'(1);
					end
					if (ex_push) begin
						cnt_q[cls_s1] <= cnt_cur + CNT_W'(1);
					end
					if (ex_bump) begin
						bump_top_q <= new_top[ADDR_W-1:0];
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= req_acc ? S_EXEC : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_HEAP_START: bump_top_q   <= cfg_wdata;
					REG_HEAP_LIMIT: heap_limit_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_s1       <= req.cmd;
			cls_s1       <= (req.cmd == CMD_FREE) ? req.free_class : sel.cls;
			too_large_s1 <= (req.cmd == CMD_ALLOC) && sel.too_large;
			addr_s1      <= req.free_address;
		end
		if (state_q == S_EXEC) begin
			res_addr_s2   <= ex_addr;
			res_cls_s2    <= ex_cls;
			res_status_s2 <= ex_status;
			from_mem_s2   <= ex_from_mem;
		end
		if (state_q == S_RESP && out_free) begin
			out_addr_q   <= from_mem_s2 ? mem_rdata : res_addr_s2;
			out_cls_q    <= res_cls_s2;
			out_status_q <= res_status_s2;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.block_address = out_addr_q;
	assign rsp.size_class    = out_cls_q;
	assign rsp.status        = out_status_q;

endmodule
